// ===== src/glr_pkg.sv =====
`timescale 1ns / 1ps
// glr_pkg: shared types, codes and constants of the gamepad latch and report block
// depends on nothing; imported by every module under src

package glr_pkg;

    // action codes of an input word
    typedef enum logic [1:0] {
        ACT_PUBLISH = 2'd0,
        ACT_LATCH   = 2'd1,
        ACT_SHORT   = 2'd2,
        ACT_DEVICE  = 2'd3
    } glr_action_t;

    // path mode codes
    localparam logic [1:0] MODE_SHORT_ONLY  = 2'd1;
    localparam logic [1:0] MODE_DEVICE_ONLY = 2'd2;
    localparam logic [1:0] MODE_RESET       = MODE_SHORT_ONLY;

    localparam int PAD_PORTS_DEF = 2;
    localparam int CMD_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    localparam logic [7:0] STICK_REST = 8'd128;

    // one pad sample
    typedef struct packed {
        logic [15:0] buttons;
        logic [7:0]  lx;
        logic [7:0]  ly;
        logic [7:0]  rx;
        logic [7:0]  ry;
        logic [7:0]  l2;
        logic [7:0]  r2;
        logic        linked;
    } glr_sample_t;

    // report job handed from front to back
    typedef struct packed {
        logic        is_device;
        glr_sample_t s;
    } glr_cmd_t;

    // one result word
    typedef struct packed {
        logic [7:0] data;
        logic [5:0] offset;
        logic       last;
    } glr_res_t;

    function automatic glr_sample_t sample_reset(input logic linked);
        glr_sample_t s;
        s         = '0;
        s.lx      = STICK_REST;
        s.ly      = STICK_REST;
        s.rx      = STICK_REST;
        s.ry      = STICK_REST;
        s.linked  = linked;
        return s;
    endfunction

endpackage

// ===== src/glr_fifo.sv =====
`timescale 1ns / 1ps
// glr_fifo: small generic register queue with count, used for jobs and results
// depends on glr_pkg for default sizes

module glr_fifo
    import glr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = CMD_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/glr_front.sv =====
`timescale 1ns / 1ps
// glr_front: accepts input words, keeps polled, seen and held pad state per port
// depends on glr_pkg; feeds report jobs into the job queue

module glr_front
    import glr_pkg::*;
#(
    parameter int PAD_PORTS = PAD_PORTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic        port,
    input  logic [15:0] button_mask,
    input  logic        link_up,
    input  logic [7:0]  left_x,
    input  logic [7:0]  left_y,
    input  logic [7:0]  right_x,
    input  logic [7:0]  right_y,
    input  logic [7:0]  l2_level,
    input  logic [7:0]  r2_level,
    input  logic        cmd_full,
    output logic        cmd_push,
    output glr_cmd_t    cmd
);

    localparam int IDX_W = (PAD_PORTS > 1) ? $clog2(PAD_PORTS) : 1;

    glr_sample_t poll_reg [PAD_PORTS];
    glr_sample_t held_reg [PAD_PORTS];
    logic [15:0] seen_reg [PAD_PORTS];

    glr_sample_t latch_val [PAD_PORTS];

    glr_action_t act;
    glr_sample_t pub;
    logic        accept;
    logic        in_range;
    logic [IDX_W-1:0] pidx;
    logic [IDX_W-1:0] sel_idx;

    assign act      = glr_action_t'(action);
    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign in_range = (int'(port) < PAD_PORTS);
    assign pidx     = IDX_W'(port);
    // a short read of a missing port reports port 0
    assign sel_idx  = in_range ? pidx : '0;

    always_comb
    begin
        pub.buttons = button_mask;
        pub.lx      = left_x;
        pub.ly      = left_y;
        pub.rx      = right_x;
        pub.ry      = right_y;
        pub.l2      = l2_level;
        pub.r2      = r2_level;
        pub.linked  = link_up;
    end

    // seen presses survive into the held frame
    always_comb
    begin
        for (int i = 0; i < PAD_PORTS; i++)
        begin
            latch_val[i]         = poll_reg[i];
            latch_val[i].buttons = poll_reg[i].buttons | seen_reg[i];
        end
    end

    assign cmd_push      = accept && (act == ACT_SHORT || act == ACT_DEVICE);
    assign cmd.is_device = (act == ACT_DEVICE);
    assign cmd.s         = (act == ACT_DEVICE) ? held_reg[0] : held_reg[sel_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAD_PORTS; i++)
            begin
                poll_reg[i] <= sample_reset(i == 0);
                held_reg[i] <= sample_reset(i == 0);
                seen_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            unique case (act)
                ACT_PUBLISH:
                begin
                    if (in_range)
                    begin
                        poll_reg[pidx] <= pub;
                        seen_reg[pidx] <= seen_reg[pidx] | button_mask;
                    end
                end
                ACT_LATCH:
                begin
                    for (int i = 0; i < PAD_PORTS; i++)
                    begin
                        held_reg[i] <= latch_val[i];
                        seen_reg[i] <= poll_reg[i].buttons;
                    end
                end
                ACT_SHORT, ACT_DEVICE:
                begin
                end
            endcase
        end
    end

endmodule

// ===== src/glr_back.sv =====
`timescale 1ns / 1ps
// glr_back: report sequencer, one result word per step, with a calibration scaling stage
// depends on glr_pkg; takes jobs from the job queue, fills the result queue

module glr_back
    import glr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  glr_cmd_t    cmd,
    output logic        cmd_pop,
    input  logic [1:0]  path_mode,
    input  logic [63:0] cal_low,
    input  logic [63:0] cal_high,
    input  logic        res_full,
    output logic        res_push,
    output glr_res_t    res
);

    localparam int B_UP    = 4;
    localparam int B_RIGHT = 5;
    localparam int B_DOWN  = 6;
    localparam int B_LEFT  = 7;
    localparam int B_L2    = 8;
    localparam int B_R2    = 9;
    localparam int B_L1    = 10;
    localparam int B_R1    = 11;
    localparam int B_TRI   = 12;
    localparam int B_CIR   = 13;
    localparam int B_CRO   = 14;
    localparam int B_SQU   = 15;

    localparam logic [4:0] SHORT_LAST   = 5'd17;
    localparam logic [4:0] DEVICE_LAST  = 5'd13;
    localparam logic [4:0] SILENT_LAST  = 5'd1;
    localparam logic [4:0] CHAN_FIRST   = 5'd6;
    localparam logic [7:0] KIND_PLAYER1 = 8'd2;

    // button shown in short report bytes 6..15
    function automatic logic [3:0] short_bit(input logic [3:0] k);
        logic [3:0] b;
        unique case (k)
            4'd0:    b = 4'(B_RIGHT);
            4'd1:    b = 4'(B_LEFT);
            4'd2:    b = 4'(B_UP);
            4'd3:    b = 4'(B_DOWN);
            4'd4:    b = 4'(B_TRI);
            4'd5:    b = 4'(B_CIR);
            4'd6:    b = 4'(B_CRO);
            4'd7:    b = 4'(B_SQU);
            4'd8:    b = 4'(B_L1);
            4'd9:    b = 4'(B_R1);
            default: b = 4'(B_RIGHT);
        endcase
        return b;
    endfunction

    // device report word offsets by step
    function automatic logic [5:0] dev_offset(input logic [4:0] st);
        logic [5:0] o;
        unique case (st)
            5'd0:    o = 6'd0;
            5'd1:    o = 6'd4;
            5'd2:    o = 6'd40;
            5'd3:    o = 6'd44;
            5'd4:    o = 6'd48;
            5'd5:    o = 6'd52;
            5'd6:    o = 6'd8;
            5'd7:    o = 6'd12;
            5'd8:    o = 6'd16;
            5'd9:    o = 6'd20;
            5'd10:   o = 6'd24;
            5'd11:   o = 6'd28;
            5'd12:   o = 6'd36;
            5'd13:   o = 6'd32;
            default: o = 6'd0;
        endcase
        return o;
    endfunction

    // 128 + (pos - neg) / 2, truncating toward zero
    function automatic logic [7:0] axis_of(input logic [7:0] neg, input logic [7:0] pos);
        logic signed [9:0] d;
        logic signed [9:0] h;
        d = $signed({2'b00, pos}) - $signed({2'b00, neg});
        h = (d + $signed({9'd0, d[9]})) >>> 1;
        return 8'(h + 10'sd128);
    endfunction

    logic [4:0]  step_reg, step_next;
    logic        s1_valid_reg;
    logic        s1_scale_reg;
    logic [7:0]  s1_data_reg;
    logic [5:0]  s1_offset_reg;
    logic        s1_last_reg;
    logic [15:0] s1_prod_reg;
    logic [7:0]  s1_lo_reg;

    logic        advance, issue, silent, last_step;
    logic [15:0] sb, db;
    logic [2:0]  chan;
    logic [7:0]  ch_val, lo, hi, l1v, r1v, l2v, r2v;
    logic        degen;
    logic [7:0]  a_data;
    logic [5:0]  a_offset;
    logic        a_scale;
    logic [15:0] a_prod;
    logic [16:0] x;
    logic [16:0] qx;
    logic [8:0]  r;

    assign advance   = !s1_valid_reg || !res_full;
    assign issue     = cmd_valid && advance;
    assign silent    = (path_mode == MODE_SHORT_ONLY) || !cmd.s.linked;
    assign last_step = cmd.is_device ? (step_reg == (silent ? SILENT_LAST : DEVICE_LAST))
                                     : (step_reg == SHORT_LAST);
    assign cmd_pop   = issue && last_step;
    assign step_next = issue ? (last_step ? '0 : step_reg + 1'b1) : step_reg;

    assign sb = (path_mode == MODE_DEVICE_ONLY) ? 16'd0 : cmd.s.buttons;
    assign db = cmd.s.buttons;

    assign chan = 3'(step_reg - CHAN_FIRST);
    assign l1v  = db[B_L1] ? 8'hFF : 8'h00;
    assign r1v  = db[B_R1] ? 8'hFF : 8'h00;
    assign l2v  = db[B_L2] ? 8'hFF : cmd.s.l2;
    assign r2v  = db[B_R2] ? 8'hFF : cmd.s.r2;
    assign lo   = cal_low[{chan, 3'b000} +: 8];
    assign hi   = cal_high[{chan, 3'b000} +: 8];
    assign degen = (hi <= lo);

    always_comb
    begin
        unique case (chan)
            3'd0: ch_val = cmd.s.lx;
            3'd1: ch_val = cmd.s.ly;
            3'd2: ch_val = axis_of(l2v, r2v);
            3'd3: ch_val = axis_of(l1v, r1v);
            3'd4: ch_val = cmd.s.rx;
            3'd5: ch_val = cmd.s.ry;
            3'd6: ch_val = db[B_TRI] ? 8'hFF : 8'h00;
            3'd7: ch_val = db[B_SQU] ? 8'hFF : 8'h00;
        endcase
    end

    // first stage: pick the word, start the calibration product
    always_comb
    begin
        a_scale = 1'b0;
        a_prod  = 16'(ch_val) * 16'(hi - lo);
        if (cmd.is_device)
        begin
            a_offset = dev_offset(step_reg);
            unique case (step_reg)
                5'd0:    a_data = silent ? 8'd0 : KIND_PLAYER1;
                5'd1:    a_data = 8'd0;
                5'd2:    a_data = ~db[7:0];
                5'd3:    a_data = ~db[15:8];
                5'd4:    a_data = 8'hFF;
                5'd5:    a_data = 8'hFF;
                default:
                begin
                    // degenerate bounds report lower bound minus one, floor zero
                    a_data  = (lo == 8'd0) ? 8'd0 : lo - 8'd1;
                    a_scale = !degen;
                end
            endcase
        end
        else
        begin
            a_offset = 6'(step_reg);
            unique case (step_reg)
                5'd0:    a_data = ~sb[7:0];
                5'd1:    a_data = ~sb[15:8];
                5'd2:    a_data = cmd.s.rx;
                5'd3:    a_data = cmd.s.ry;
                5'd4:    a_data = cmd.s.lx;
                5'd5:    a_data = cmd.s.ly;
                5'd16:   a_data = sb[B_L2] ? cmd.s.l2 : 8'd0;
                5'd17:   a_data = sb[B_R2] ? cmd.s.r2 : 8'd0;
                default: a_data = sb[short_bit(4'(step_reg - CHAN_FIRST))] ? 8'hFF : 8'h00;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_scale_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (advance)
            begin
                s1_valid_reg <= issue;
                s1_scale_reg <= a_scale;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_data_reg   <= a_data;
            s1_offset_reg <= a_offset;
            s1_last_reg   <= last_step;
            s1_prod_reg   <= a_prod;
            s1_lo_reg     <= lo;
        end
    end

    // second stage: (prod + 127) / 255 by add and shift, exact below 65535
    assign x  = 17'(s1_prod_reg) + 17'd127;
    assign qx = x + (x >> 8) + 17'd1;
    assign r  = 9'(s1_lo_reg) + 9'(qx[15:8]);

    assign res_push   = s1_valid_reg && !res_full;
    assign res.data   = s1_scale_reg ? r[7:0] : s1_data_reg;
    assign res.offset = s1_offset_reg;
    assign res.last   = s1_last_reg;

endmodule

// ===== src/gamepad_latch_and_report.sv =====
`timescale 1ns / 1ps
// gamepad_latch_and_report: top level, config registers, front, job queue, back, result queue
// depends on glr_pkg, glr_front, glr_fifo, glr_back
//
// channel   direction  handshake            word
// input     in         push / full          action, port, button_mask, link_up, sticks, triggers
// result    out        empty / pop          data, offset, last
// config    in         cfg_wr_en            cfg_index, cfg_data (64 bits)
//
// publish and latch take effect at the accepting edge and give no result
// a short read gives 18 words, a device report 14 (2 when silenced), one word per clock while the result queue has room
// the back sequencer sets that rate: one step per word, held in its stage register, then queued
// the job queue lets new words be accepted while a report is still being sent
// reset clears all pad state to neutral sticks and released buttons, port 0 linked
// a full result queue stalls the back only; a full job queue raises full

module gamepad_latch_and_report
    import glr_pkg::*;
#(
    parameter int PAD_PORTS = PAD_PORTS_DEF,
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int RES_DEPTH = RES_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic        port,
    input  logic [15:0] button_mask,
    input  logic        link_up,
    input  logic [7:0]  left_x,
    input  logic [7:0]  left_y,
    input  logic [7:0]  right_x,
    input  logic [7:0]  right_y,
    input  logic [7:0]  l2_level,
    input  logic [7:0]  r2_level,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  data,
    output logic [5:0]  offset,
    output logic        last,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam logic [1:0] CFG_PATH_MODE = 2'd0;
    localparam logic [1:0] CFG_CAL_LOW   = 2'd1;
    localparam logic [1:0] CFG_CAL_HIGH  = 2'd2;

    logic [1:0]  path_mode_reg;
    logic [63:0] cal_low_reg;
    logic [63:0] cal_high_reg;

    // front to job queue
    logic        cmd_push, cmd_full, cmd_empty, cmd_pop;
    glr_cmd_t    cmd_in, cmd_head;

    // back to result queue
    logic        res_push, res_full;
    glr_res_t    res_in, res_head;

    // config registers, written only while idle: a rule for the user, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_mode_reg <= MODE_RESET;
            cal_low_reg   <= '0;
            cal_high_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PATH_MODE: path_mode_reg <= cfg_data[1:0];
                CFG_CAL_LOW:   cal_low_reg   <= cfg_data;
                CFG_CAL_HIGH:  cal_high_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    glr_front #(
        .PAD_PORTS (PAD_PORTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .port        (port),
        .button_mask (button_mask),
        .link_up     (link_up),
        .left_x      (left_x),
        .left_y      (left_y),
        .right_x     (right_x),
        .right_y     (right_y),
        .l2_level    (l2_level),
        .r2_level    (r2_level),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    // job queue: snapshot of the held sample taken at accept
    glr_fifo #(
        .WIDTH ($bits(glr_cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_head),
        .empty   (cmd_empty)
    );

    glr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .path_mode (path_mode_reg),
        .cal_low   (cal_low_reg),
        .cal_high  (cal_high_reg),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue, oldest word on the ports while not empty
    glr_fifo #(
        .WIDTH ($bits(glr_res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_head),
        .empty   (empty)
    );

    assign data   = res_head.data;
    assign offset = res_head.offset;
    assign last   = res_head.last;

endmodule

// ===== tb/glr_tb_pkg.sv =====
`timescale 1ns / 1ps
// glr_tb_pkg: register indexes and path mode codes shared by the testbench files
// depends on glr_pkg for the path mode codes that the block itself names

package glr_tb_pkg;
    import glr_pkg::*;

    // config register indexes
    localparam logic [1:0] REG_PATH_MODE = 2'd0;
    localparam logic [1:0] REG_CAL_LOW   = 2'd1;
    localparam logic [1:0] REG_CAL_HIGH  = 2'd2;

    // path mode codes not named by the block package
    localparam logic [1:0] MODE_BOTH       = 2'd0;
    localparam logic [1:0] MODE_BOTH_ALIAS = 2'd3;

endpackage

// ===== tb/glr_checker.sv =====
`timescale 1ns / 1ps
// glr_checker: watches the input, config and result channels, predicts report words
// depends on glr_pkg and glr_tb_pkg; hands the mismatch count and words still due to tb_top

module glr_checker
    import glr_pkg::*;
    import glr_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  action,
    input  logic        port,
    input  logic [15:0] button_mask,
    input  logic        link_up,
    input  logic [7:0]  left_x,
    input  logic [7:0]  left_y,
    input  logic [7:0]  right_x,
    input  logic [7:0]  right_y,
    input  logic [7:0]  l2_level,
    input  logic [7:0]  r2_level,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  data,
    input  logic [5:0]  offset,
    input  logic        last,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          words_due,
    output int          mismatches
);

    localparam int PORTS = PAD_PORTS_DEF;
    localparam int SHOWN = 10;

    // button bit positions
    localparam int BTN_UP    = 4;
    localparam int BTN_RIGHT = 5;
    localparam int BTN_DOWN  = 6;
    localparam int BTN_LEFT  = 7;
    localparam int BTN_L2    = 8;
    localparam int BTN_R2    = 9;
    localparam int BTN_L1    = 10;
    localparam int BTN_R1    = 11;
    localparam int BTN_TRI   = 12;
    localparam int BTN_CIR   = 13;
    localparam int BTN_CRO   = 14;
    localparam int BTN_SQU   = 15;

    localparam logic [7:0] KIND_FIRST_PLAYER = 8'd2;

    glr_sample_t polled [PORTS];
    glr_sample_t held   [PORTS];
    logic [15:0] seen   [PORTS];
    logic [1:0]  mode;
    logic [63:0] cal_lo;
    logic [63:0] cal_hi;
    glr_res_t    report_words [$];

    function automatic void owe(input logic [7:0] d, input logic [5:0] o, input logic l);
        glr_res_t w;
        w.data   = d;
        w.offset = o;
        w.last   = l;
        report_words.push_back(w);
    endfunction

    function automatic logic [7:0] press_byte(input logic b);
        return b ? 8'hFF : 8'h00;
    endfunction

    // signed difference halved toward zero around the rest point
    function automatic logic [7:0] trigger_axis(input int neg, input int pos);
        int v;
        v = 128 + (pos - neg) / 2;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic logic [7:0] fit_cal(input int ch, input logic [7:0] level);
        int lo;
        int hi;
        int r;
        lo = int'(cal_lo[8*ch +: 8]);
        hi = int'(cal_hi[8*ch +: 8]);
        if (hi <= lo)
            return (lo > 0) ? 8'(lo - 1) : 8'd0;
        r = lo + (int'(level) * (hi - lo) + 127) / 255;
        if (r > hi)
            r = hi;
        return 8'(r);
    endfunction

    // channels 6 and 7 trade places in the offset layout
    function automatic logic [5:0] slot_offset(input int j);
        int slot;
        slot = (j == 6) ? 7 : (j == 7) ? 6 : j;
        return 6'(8 + 4 * slot);
    endfunction

    function automatic void queue_short(input logic p);
        glr_sample_t s;
        logic [15:0] b;
        logic [7:0]  d [18];
        s = held[p];
        b = (mode == MODE_DEVICE_ONLY) ? 16'h0000 : s.buttons;
        d[0]  = ~b[7:0];
        d[1]  = ~b[15:8];
        d[2]  = s.rx;
        d[3]  = s.ry;
        d[4]  = s.lx;
        d[5]  = s.ly;
        d[6]  = press_byte(b[BTN_RIGHT]);
        d[7]  = press_byte(b[BTN_LEFT]);
        d[8]  = press_byte(b[BTN_UP]);
        d[9]  = press_byte(b[BTN_DOWN]);
        d[10] = press_byte(b[BTN_TRI]);
        d[11] = press_byte(b[BTN_CIR]);
        d[12] = press_byte(b[BTN_CRO]);
        d[13] = press_byte(b[BTN_SQU]);
        d[14] = press_byte(b[BTN_L1]);
        d[15] = press_byte(b[BTN_R1]);
        d[16] = b[BTN_L2] ? s.l2 : 8'h00;
        d[17] = b[BTN_R2] ? s.r2 : 8'h00;
        for (int i = 0; i < 18; i++)
            owe(d[i], 6'(i), i == 17);
    endfunction

    function automatic void queue_device();
        glr_sample_t s;
        logic [15:0] b;
        logic [31:0] dig;
        logic [7:0]  ch [8];
        int          l1;
        int          r1;
        int          l2;
        int          r2;
        s = held[0];
        b = s.buttons;
        // silenced or unplugged: two zero words only
        if (mode == MODE_SHORT_ONLY || !s.linked)
        begin
            owe(8'd0, 6'd0, 1'b0);
            owe(8'd0, 6'd4, 1'b1);
            return;
        end
        owe(KIND_FIRST_PLAYER, 6'd0, 1'b0);
        owe(8'd0, 6'd4, 1'b0);
        dig = {16'hFFFF, ~b};
        owe(dig[7:0], 6'd40, 1'b0);
        owe(dig[15:8], 6'd44, 1'b0);
        owe(dig[23:16], 6'd48, 1'b0);
        owe(dig[31:24], 6'd52, 1'b0);
        l1 = b[BTN_L1] ? 255 : 0;
        r1 = b[BTN_R1] ? 255 : 0;
        l2 = b[BTN_L2] ? 255 : int'(s.l2);
        r2 = b[BTN_R2] ? 255 : int'(s.r2);
        ch[0] = s.lx;
        ch[1] = s.ly;
        ch[2] = trigger_axis(l2, r2);
        ch[3] = trigger_axis(l1, r1);
        ch[4] = s.rx;
        ch[5] = s.ry;
        ch[6] = press_byte(b[BTN_TRI]);
        ch[7] = press_byte(b[BTN_SQU]);
        for (int j = 0; j < 8; j++)
            owe(fit_cal(j, ch[j]), slot_offset(j), j == 7);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        glr_res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < PORTS; i++)
            begin
                held[i]        = '0;
                held[i].lx     = STICK_REST;
                held[i].ly     = STICK_REST;
                held[i].rx     = STICK_REST;
                held[i].ry     = STICK_REST;
                held[i].linked = (i == 0);
                polled[i]      = held[i];
                seen[i]        = '0;
            end
            mode   = MODE_RESET;
            cal_lo = '0;
            cal_hi = '0;
            report_words.delete();
            words_due = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (report_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN)
                        $display("%0t: word with nothing due: data %02h offset %0d last %0b",
                                 $time, data, offset, last);
                end
                else
                begin
                    want = report_words.pop_front();
                    if (data !== want.data || offset !== want.offset || last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= SHOWN)
                            $display({"%0t: mismatch: want data %02h offset %0d last %0b,",
                                      " got data %02h offset %0d last %0b"},
                                     $time, want.data, want.offset, want.last,
                                     data, offset, last);
                    end
                end
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_PATH_MODE: mode   = cfg_data[1:0];
                    REG_CAL_LOW:   cal_lo = cfg_data;
                    REG_CAL_HIGH:  cal_hi = cfg_data;
                    default: ;
                endcase
            end

            if (push && !full)
            begin
                case (glr_action_t'(action))
                    ACT_PUBLISH:
                    begin
                        polled[port].buttons = button_mask;
                        polled[port].linked  = link_up;
                        polled[port].lx      = left_x;
                        polled[port].ly      = left_y;
                        polled[port].rx      = right_x;
                        polled[port].ry      = right_y;
                        polled[port].l2      = l2_level;
                        polled[port].r2      = r2_level;
                        seen[port]           = seen[port] | button_mask;
                    end
                    ACT_LATCH:
                    begin
                        for (int i = 0; i < PORTS; i++)
                        begin
                            held[i]         = polled[i];
                            held[i].buttons = polled[i].buttons | seen[i];
                            seen[i]         = polled[i].buttons;
                        end
                    end
                    ACT_SHORT:  queue_short(port);
                    ACT_DEVICE: queue_device();
                    default: ;
                endcase
            end

            words_due = report_words.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: clock, reset, stimulus and verdict for gamepad_latch_and_report
// depends on glr_pkg, glr_tb_pkg, glr_checker and the block under src

module tb_top;
    import glr_pkg::*;
    import glr_tb_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 32;   // quiet time after the last report word
    localparam int PHASE_WORDS   = 60;   // minimum input words per random phase
    localparam int RUN_LIMIT_NS  = 8_000_000;

    // one input word as the sender sees it
    typedef struct packed {
        glr_action_t act;
        logic        port;
        logic [15:0] bm;
        logic        link;
        logic [7:0]  lx;
        logic [7:0]  ly;
        logic [7:0]  rx;
        logic [7:0]  ry;
        logic [7:0]  l2;
        logic [7:0]  r2;
    } pad_word_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  action;
    logic        port;
    logic [15:0] button_mask;
    logic        link_up;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  l2_level;
    logic [7:0]  r2_level;
    logic        empty;
    logic        pop;
    logic [7:0]  data;
    logic [5:0]  offset;
    logic        last;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    int words_due;
    int mismatches;
    int words_sent;

    // stretches where one side never idles
    bit tx_eager;
    bit rx_eager;

    gamepad_latch_and_report DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .port        (port),
        .button_mask (button_mask),
        .link_up     (link_up),
        .left_x      (left_x),
        .left_y      (left_y),
        .right_x     (right_x),
        .right_y     (right_y),
        .l2_level    (l2_level),
        .r2_level    (r2_level),
        .empty       (empty),
        .pop         (pop),
        .data        (data),
        .offset      (offset),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // watches all three channels and predicts every report word
    glr_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .port        (port),
        .button_mask (button_mask),
        .link_up     (link_up),
        .left_x      (left_x),
        .left_y      (left_y),
        .right_x     (right_x),
        .right_y     (right_y),
        .l2_level    (l2_level),
        .r2_level    (r2_level),
        .empty       (empty),
        .pop         (pop),
        .data        (data),
        .offset      (offset),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .words_due   (words_due),
        .mismatches  (mismatches)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop in case a handshake hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // fully random word, any action
    function automatic pad_word_t any_word();
        pad_word_t w;
        w.act  = glr_action_t'($urandom_range(0, 3));
        w.port = 1'($urandom_range(0, 1));
        w.bm   = 16'($urandom);
        w.link = 1'($urandom_range(0, 1));
        w.lx   = 8'($urandom);
        w.ly   = 8'($urandom);
        w.rx   = 8'($urandom);
        w.ry   = 8'($urandom);
        w.l2   = 8'($urandom);
        w.r2   = 8'($urandom);
        return w;
    endfunction

    // command word with random payload, payload is ignored by the block
    function automatic pad_word_t op_word(input glr_action_t a, input logic p);
        pad_word_t w;
        w      = any_word();
        w.act  = a;
        w.port = p;
        return w;
    endfunction

    // publish word with fixed content, for the directed part
    function automatic pad_word_t pad_sample(input logic p, input logic [15:0] bm,
                                             input logic link, input logic [7:0] lx,
                                             input logic [7:0] ly, input logic [7:0] rx,
                                             input logic [7:0] ry, input logic [7:0] l2,
                                             input logic [7:0] r2);
        pad_word_t w;
        w.act  = ACT_PUBLISH;
        w.port = p;
        w.bm   = bm;
        w.link = link;
        w.lx   = lx;
        w.ly   = ly;
        w.rx   = rx;
        w.ry   = ry;
        w.l2   = l2;
        w.r2   = r2;
        return w;
    endfunction

    // publish word with random content; port 0 is mostly plugged in so
    // device reports get past the silenced case
    function automatic pad_word_t sample_word(input logic p);
        pad_word_t w;
        w      = any_word();
        w.act  = ACT_PUBLISH;
        w.port = p;
        case ($urandom_range(0, 7))
            0:       w.bm = 16'h0000;
            1:       w.bm = 16'hFFFF;
            2, 3:    w.bm = 16'($urandom & $urandom & $urandom);
            default: w.bm = 16'($urandom);
        endcase
        if (p == 1'b0)
            w.link = ($urandom_range(0, 99) < 85);
        return w;
    endfunction

    // offer one word: random gap first, then hold push until accepted;
    // entered and left at a falling edge, push stays high on the way out so
    // back-to-back words need no drop
    task automatic put_word(input pad_word_t w);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push        = 1'b1;
        action      = w.act;
        port        = w.port;
        button_mask = w.bm;
        link_up     = w.link;
        left_x      = w.lx;
        left_y      = w.ly;
        right_x     = w.rx;
        right_y     = w.ry;
        l2_level    = w.l2;
        r2_level    = w.r2;
        @(posedge clk);
        while (full)
            @(posedge clk);
        words_sent++;
        if ($urandom_range(0, 29) == 0)
            tx_eager = !tx_eager;
        @(negedge clk);
    endtask

    // stop sending and wait for every predicted word, then a quiet stretch
    // so no job is still in flight
    task automatic settle();
        push = 1'b0;
        while (words_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [63:0] lo,
                              input logic [63:0] hi);
        write_reg(REG_PATH_MODE, {62'd0, mode});
        write_reg(REG_CAL_LOW, lo);
        write_reg(REG_CAL_HIGH, hi);
    endtask

    // frame-like sequence: a few publishes, a latch, then some reads
    task automatic well_formed_burst();
        repeat ($urandom_range(1, 3))
            put_word(sample_word(1'($urandom_range(0, 1))));
        put_word(op_word(ACT_LATCH, 1'($urandom_range(0, 1))));
        repeat ($urandom_range(1, 3))
            put_word(op_word($urandom_range(0, 1) ? ACT_SHORT : ACT_DEVICE,
                             1'($urandom_range(0, 1))));
    endtask

    // drain, reprogram, then mostly frame sequences with some noise words
    task automatic random_phase(input logic [1:0] mode, input logic [63:0] lo,
                                input logic [63:0] hi);
        int goal;
        settle();
        set_config(mode, lo, hi);
        goal = words_sent + PHASE_WORDS;
        while (words_sent < goal)
        begin
            if ($urandom_range(0, 99) < 80)
                well_formed_burst();
            else
                put_word(any_word());
        end
    endtask

    // result side: random stall per word, sometimes none for a while
    initial
    begin : take_results
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = rx_eager ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                pop = 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop = 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            if ($urandom_range(0, 39) == 0)
                rx_eager = !rx_eager;
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic [63:0] lo_b;
        logic [63:0] hi_b;

        rst_n       = 1'b0;
        push        = 1'b0;
        action      = ACT_PUBLISH;
        port        = 1'b0;
        button_mask = '0;
        link_up     = 1'b0;
        left_x      = '0;
        left_y      = '0;
        right_x     = '0;
        right_y     = '0;
        l2_level    = '0;
        r2_level    = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_PATH_MODE;
        cfg_data    = '0;
        words_sent  = 0;
        tx_eager    = 1'b0;
        rx_eager    = 1'b0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, reset config: short format only, device reports silenced
        // reads straight out of reset show neutral sticks, nothing pressed
        put_word(op_word(ACT_SHORT, 1'b0));
        put_word(op_word(ACT_SHORT, 1'b1));
        put_word(op_word(ACT_DEVICE, 1'b0));
        // everything pressed with stick extremes, then an odd pattern on port 1
        put_word(pad_sample(1'b0, 16'hFFFF, 1'b1, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h01));
        put_word(pad_sample(1'b1, 16'hA5A5, 1'b0, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h7F));
        put_word(op_word(ACT_LATCH, 1'b0));
        put_word(op_word(ACT_SHORT, 1'b0));
        put_word(op_word(ACT_SHORT, 1'b1));
        // release before the next latch: the press must still be reported once
        put_word(pad_sample(1'b0, 16'h0000, 1'b1, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00));
        put_word(op_word(ACT_LATCH, 1'b1));
        put_word(op_word(ACT_SHORT, 1'b0));
        put_word(op_word(ACT_LATCH, 1'b0));
        put_word(op_word(ACT_SHORT, 1'b0));

        // directed, both formats, full calibration range
        settle();
        set_config(MODE_BOTH, 64'h0, '1);
        put_word(op_word(ACT_DEVICE, 1'b1));
        // triggers, shoulders, triangle and square pressed
        put_word(pad_sample(1'b0, 16'h9F00, 1'b1, 8'h10, 8'hF0, 8'h33, 8'hCC, 8'd10, 8'd200));
        put_word(op_word(ACT_LATCH, 1'b0));
        put_word(op_word(ACT_DEVICE, 1'b0));
        put_word(op_word(ACT_SHORT, 1'b0));
        // one shoulder only, right trigger analog only: axes at their ends
        put_word(pad_sample(1'b0, 16'h0400, 1'b1, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF));
        put_word(op_word(ACT_LATCH, 1'b0));
        put_word(op_word(ACT_LATCH, 1'b0));
        put_word(op_word(ACT_DEVICE, 1'b0));
        // port 0 unplugged: device report shrinks to two words
        put_word(pad_sample(1'b0, 16'h5A5A, 1'b0, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06));
        put_word(op_word(ACT_LATCH, 1'b0));
        put_word(op_word(ACT_DEVICE, 1'b0));

        // random phases through the path modes and calibration extremes
        random_phase(MODE_BOTH, 64'h0, '1);
        random_phase(MODE_DEVICE_ONLY, {$urandom, $urandom}, {$urandom, $urandom});
        // upper equal to lower on every channel
        random_phase(MODE_BOTH_ALIAS, '1, '1);
        random_phase(MODE_SHORT_ONLY, {$urandom, $urandom}, 64'h0);
        // well-ordered bounds on every channel
        for (int j = 0; j < 8; j++)
        begin
            lo_b[8*j +: 8] = 8'($urandom_range(0, 127));
            hi_b[8*j +: 8] = 8'($urandom_range(128, 255));
        end
        random_phase(MODE_BOTH_ALIAS, lo_b, hi_b);
        // both bounds zero: every channel reports zero
        random_phase(MODE_DEVICE_ONLY, 64'h0, 64'h0);

        settle();
        if (mismatches == 0 && words_due == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== gamepad_latch_and_report.f =====
src/glr_pkg.sv
src/glr_fifo.sv
src/glr_front.sv
src/glr_back.sv
src/gamepad_latch_and_report.sv
tb/glr_tb_pkg.sv
tb/glr_checker.sv
tb/tb_top.sv
